// ===== rtl/stsr_pkg.sv =====
// ----------------------------------------------------------------------------
// stsr_pkg
// Types, codes and sizes shared by the segmented transfer receiver.
// ----------------------------------------------------------------------------
package stsr_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 8;
  localparam int SEG_W    = 16;
  localparam int KIND_W   = 2;
  localparam int ERR_W    = 3;
  localparam int TMO_W    = 8;
  localparam int MTU_W    = 10;
  localparam int ELAP_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MTU     = 1'd1;

  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 8'd20;
  localparam logic [MTU_W-1:0]  MTU_RESET     = 10'd23;
  localparam logic [MTU_W-1:0]  MTU_OVERHEAD  = 10'd28;
  localparam logic [ELAP_W-1:0] ELAPSED_MAX   = 9'd511;
  localparam logic signed [STATUS_W-1:0] STATUS_NOT_FOUND = -8'sd1;
  localparam logic [SEG_W-1:0]  AMOUNT_CAP    = SEG_W'(MAX_SEGMENTS);

  localparam logic [ACTION_W-1:0] ACT_GET_ACK = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SEGMENT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_EXIT    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_SEG_ACK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIN_ACK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RETX    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FAIL    = 2'd3;

  localparam logic [ERR_W-1:0] ERR_TIMEOUT   = 3'd0;
  localparam logic [ERR_W-1:0] ERR_EXIT      = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NOT_FOUND = 3'd2;
  localparam logic [ERR_W-1:0] ERR_MTU_SMALL = 3'd3;
  localparam logic [ERR_W-1:0] ERR_AMOUNT    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_ORDER     = 3'd5;
  localparam logic [ERR_W-1:0] ERR_CAPACITY  = 3'd6;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_RECV,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic             set;
    logic [IDX_W-1:0] set_idx;
    logic [IDX_W-1:0] rd_idx;
  } map_ctrl_t;

  typedef struct packed {
    logic             rd_bit;
    logic [CNT_W-1:0] count;
  } map_stat_t;

endpackage

// ===== rtl/stsr_rx_map.sv =====
// ----------------------------------------------------------------------------
// stsr_rx_map
// Received-segment map with one flag per index and a count of distinct
// segments; reset clears every flag.
// ----------------------------------------------------------------------------
module stsr_rx_map import stsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  map_ctrl_t ctrl,
  output map_stat_t stat
);

  logic [MAX_SEGMENTS-1:0] map_r;
  logic [MAX_SEGMENTS-1:0] map_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;

  always_comb begin
    map_nxt   = map_r;
    count_nxt = count_r;
    if (ctrl.set && !map_r[ctrl.set_idx]) begin
      map_nxt[ctrl.set_idx] = 1'b1;
      count_nxt             = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r   <= '0;
      count_r <= '0;
    end else begin
      map_r   <= map_nxt;
      count_r <= count_nxt;
    end
  end

  assign stat.rd_bit = map_r[ctrl.rd_idx];
  assign stat.count  = count_r;

endmodule

// ===== rtl/segmented_transfer_receiver_core.sv =====
// ----------------------------------------------------------------------------
// segmented_transfer_receiver_core
// Receiver side of a segmented transfer: get-ack, segment tracking, finish
// with retransfer requests, silence timeout and exit.
// ----------------------------------------------------------------------------
// A beat is taken into an item register and evaluated in the next cycle.
// Once the amount is known, a finish with missing segments then walks the
// received map one index a cycle through a single flag test, holding while a
// retransfer request meets a stalled full output register, and gives one
// retransfer request per missing index. A result waits in the output
// register while the next beat is taken; evaluation holds only when a new
// result meets a full output register that is stalled.
module segmented_transfer_receiver_core import stsr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ACTION_W-1:0]          in_action,
  input  logic signed [STATUS_W-1:0]   in_ack_status,
  input  logic                         in_name_matches,
  input  logic [SEG_W-1:0]             in_seg_order,
  input  logic [SEG_W-1:0]             in_seg_amount,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [KIND_W-1:0]            out_kind,
  output logic [SEG_W-1:0]             out_order,
  output logic [SEG_W-1:0]             out_amount,
  output logic                         out_finish_status,
  output logic [ERR_W-1:0]             out_error_code,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [TMO_W-1:0]  timeout_r;
  logic [MTU_W-1:0]  mtu_r;
  logic [ELAP_W-1:0] elapsed_r, elapsed_nxt;
  logic              known_r, known_nxt;
  logic [CNT_W-1:0]  latched_r, latched_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]  miss_r, miss_nxt;

  logic [ACTION_W-1:0]        item_action_r;
  logic signed [STATUS_W-1:0] item_status_r;
  logic                       item_matches_r;
  logic [SEG_W-1:0]           item_order_r;
  logic [SEG_W-1:0]           item_amount_r;

  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [SEG_W-1:0]  out_order_r, out_order_nxt;
  logic [SEG_W-1:0]  out_amount_r, out_amount_nxt;
  logic              out_fin_r, out_fin_nxt;
  logic [ERR_W-1:0]  out_err_r, out_err_nxt;
  logic              out_last_r, out_last_nxt;

  logic        in_take;
  logic        out_free;
  map_ctrl_t   map_ctrl;
  map_stat_t   map_stat;

  // evaluation of the held item
  logic              ev_emit;
  logic [KIND_W-1:0] ev_kind;
  logic [SEG_W-1:0]  ev_order;
  logic [SEG_W-1:0]  ev_amount;
  logic              ev_fin;
  logic [ERR_W-1:0]  ev_err;
  logic              ev_last;
  phase_t            ev_phase;
  logic [ELAP_W-1:0] ev_elapsed;
  logic              ev_latch;
  logic              ev_set;
  logic              ev_scan;
  logic [ELAP_W-1:0] el_inc;
  logic [SEG_W-1:0]  eff_amount;
  logic              commit;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  stsr_rx_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (map_ctrl),
    .stat  (map_stat)
  );

  always_comb begin
    el_inc     = (elapsed_r < ELAPSED_MAX) ? elapsed_r + ELAP_W'(1) : elapsed_r;
    eff_amount = known_r ? SEG_W'(latched_r) : item_amount_r;
    ev_emit    = 1'b0;
    ev_kind    = KIND_SEG_ACK;
    ev_order   = '0;
    ev_amount  = '0;
    ev_fin     = 1'b0;
    ev_err     = ERR_TIMEOUT;
    ev_last    = 1'b1;
    ev_phase   = phase_r;
    ev_elapsed = elapsed_r;
    ev_latch   = 1'b0;
    ev_set     = 1'b0;
    ev_scan    = 1'b0;
    if (phase_r == PH_WAIT || phase_r == PH_RECV) begin
      if (item_action_r == ACT_EXIT) begin
        ev_emit  = 1'b1;
        ev_kind  = KIND_FAIL;
        ev_err   = ERR_EXIT;
        ev_phase = PH_FAIL;
      end else if (item_action_r == ACT_TICK) begin
        ev_elapsed = el_inc;
        if (el_inc > {1'b0, timeout_r}) begin
          ev_emit  = 1'b1;
          ev_kind  = KIND_FAIL;
          ev_err   = ERR_TIMEOUT;
          ev_phase = PH_FAIL;
        end
      end else if (phase_r == PH_WAIT) begin
        if (item_action_r == ACT_GET_ACK) begin
          if (item_status_r == STATUS_NOT_FOUND) begin
            ev_emit  = 1'b1;
            ev_kind  = KIND_FAIL;
            ev_err   = ERR_NOT_FOUND;
            ev_phase = PH_FAIL;
          end else if (mtu_r <= MTU_OVERHEAD) begin
            ev_emit  = 1'b1;
            ev_kind  = KIND_FAIL;
            ev_err   = ERR_MTU_SMALL;
            ev_phase = PH_FAIL;
          end else begin
            ev_phase   = PH_RECV;
            ev_elapsed = '0;
          end
        end
      end else if (item_action_r == ACT_SEGMENT) begin
        if (item_matches_r) begin
          if (!known_r && item_amount_r > AMOUNT_CAP) begin
            ev_emit  = 1'b1;
            ev_kind  = KIND_FAIL;
            ev_err   = ERR_CAPACITY;
            ev_phase = PH_FAIL;
          end else if (item_amount_r != eff_amount) begin
            ev_emit  = 1'b1;
            ev_kind  = KIND_FAIL;
            ev_err   = ERR_AMOUNT;
            ev_phase = PH_FAIL;
          end else if (item_order_r >= item_amount_r) begin
            ev_emit  = 1'b1;
            ev_kind  = KIND_FAIL;
            ev_err   = ERR_ORDER;
            ev_phase = PH_FAIL;
          end else begin
            ev_latch   = !known_r;
            ev_set     = 1'b1;
            ev_elapsed = '0;
            ev_emit    = 1'b1;
            ev_kind    = KIND_SEG_ACK;
            ev_order   = item_order_r;
            ev_amount  = item_amount_r;
          end
        end
      end else if (item_action_r == ACT_FINISH) begin
        ev_elapsed = '0;
        ev_emit    = 1'b1;
        ev_kind    = KIND_FIN_ACK;
        if (known_r && map_stat.count == latched_r) begin
          ev_phase = PH_DONE;
        end else begin
          ev_fin  = 1'b1;
          ev_last = !known_r;
          ev_scan = known_r;
        end
      end
    end
  end

  assign commit = !ev_emit || out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (commit) state_nxt = ev_scan ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (!map_stat.rd_bit && out_free && miss_r == CNT_W'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    elapsed_nxt    = elapsed_r;
    known_nxt      = known_r;
    latched_nxt    = latched_r;
    scan_idx_nxt   = scan_idx_r;
    miss_nxt       = miss_r;
    map_ctrl.set     = 1'b0;
    map_ctrl.set_idx = item_order_r[IDX_W-1:0];
    map_ctrl.rd_idx  = scan_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_order_nxt  = out_order_r;
    out_amount_nxt = out_amount_r;
    out_fin_nxt    = out_fin_r;
    out_err_nxt    = out_err_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_EVAL: begin
        if (commit) begin
          phase_nxt    = ev_phase;
          elapsed_nxt  = ev_elapsed;
          map_ctrl.set = ev_set;
          if (ev_latch) begin
            known_nxt   = 1'b1;
            latched_nxt = item_amount_r[CNT_W-1:0];
          end
          scan_idx_nxt = '0;
          miss_nxt     = latched_r - map_stat.count;
          if (ev_emit) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = ev_kind;
            out_order_nxt  = ev_order;
            out_amount_nxt = ev_amount;
            out_fin_nxt    = ev_fin;
            out_err_nxt    = ev_err;
            out_last_nxt   = ev_last;
          end
        end
      end
      ST_SCAN: begin
        if (map_stat.rd_bit) begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_RETX;
          out_order_nxt  = SEG_W'(scan_idx_r);
          out_amount_nxt = '0;
          out_fin_nxt    = 1'b0;
          out_err_nxt    = ERR_TIMEOUT;
          out_last_nxt   = (miss_r == CNT_W'(1));
          miss_nxt       = miss_r - CNT_W'(1);
          scan_idx_nxt   = scan_idx_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_WAIT;
      timeout_r   <= TIMEOUT_RESET;
      mtu_r       <= MTU_RESET;
      elapsed_r   <= '0;
      known_r     <= 1'b0;
      latched_r   <= '0;
      scan_idx_r  <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      known_r     <= known_nxt;
      latched_r   <= latched_nxt;
      scan_idx_r  <= scan_idx_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT: timeout_r <= cfg_wdata[TMO_W-1:0];
          REG_MTU:     mtu_r     <= cfg_wdata[MTU_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_action_r  <= in_action;
      item_status_r  <= in_ack_status;
      item_matches_r <= in_name_matches;
      item_order_r   <= in_seg_order;
      item_amount_r  <= in_seg_amount;
    end
    out_kind_r   <= out_kind_nxt;
    out_order_r  <= out_order_nxt;
    out_amount_r <= out_amount_nxt;
    out_fin_r    <= out_fin_nxt;
    out_err_r    <= out_err_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_order         = out_order_r;
  assign out_amount        = out_amount_r;
  assign out_finish_status = out_fin_r;
  assign out_error_code    = out_err_r;
  assign out_last          = out_last_r;

endmodule

// ===== rtl/stsr_checker.sv =====
// ----------------------------------------------------------------------------
// stsr_checker
// Port-level checks on the result channel of the transfer receiver, bound
// to the top level.
// ----------------------------------------------------------------------------
module stsr_checker import stsr_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [KIND_W-1:0]          out_kind,
  input logic [SEG_W-1:0]           out_order,
  input logic [SEG_W-1:0]           out_amount,
  input logic                       out_finish_status,
  input logic [ERR_W-1:0]           out_error_code,
  input logic                       out_last
);

  a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_order)
      && $stable(out_last))
    else $error("stalled result beat changed");

  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FAIL |-> out_last && out_order == '0)
    else $error("failure beat not final");

  a_ack_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SEG_ACK |-> out_last && out_order < out_amount
      && out_amount <= AMOUNT_CAP)
    else $error("segment ack out of range");

  a_retx_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_RETX |-> out_amount == '0 && !out_finish_status
      && out_error_code == ERR_TIMEOUT && out_order < AMOUNT_CAP)
    else $error("retransfer request malformed");

endmodule

bind segmented_transfer_receiver_core stsr_checker u_stsr_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segmented transfer receiver. A short table of
// beats walks the waiting phase, the first segments and an early finish, then
// random traffic keeps one transfer alive with segments, duplicates, ticks,
// foreign segments and finish scans under three register settings, and a
// randomly chosen terminal event closes it. Every reply is checked against a
// table entry or a behavioural predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stsr_pkg::*;

  localparam int RANDOM_ITEMS = 480;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DIRECTED_ROWS = 17;

  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_C = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic signed [STATUS_W-1:0] status;
    logic                       name_hit;
    logic [SEG_W-1:0]           order;
    logic [SEG_W-1:0]           amount;
  } beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEG_W-1:0]  order;
    logic [SEG_W-1:0]  amount;
    logic              fin;
    logic [ERR_W-1:0]  err;
    logic              last;
  } reply_t;

  typedef struct {
    beat_t  b;
    bit     typed;
    reply_t r;
  } dir_row_t;

  typedef enum {END_COMPLETE, END_EXIT, END_TIMEOUT, END_AMOUNT, END_ORDER} ending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACTION_W-1:0] in_action = '0;
  logic signed [STATUS_W-1:0] in_ack_status = '0;
  logic in_name_matches = 1'b0;
  logic [SEG_W-1:0] in_seg_order = '0;
  logic [SEG_W-1:0] in_seg_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [SEG_W-1:0] out_order;
  logic [SEG_W-1:0] out_amount;
  logic out_finish_status;
  logic [ERR_W-1:0] out_error_code;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  phase_t rx_phase;
  logic [MAX_SEGMENTS-1:0] seg_seen;
  int seg_count;
  int amt_latched;
  bit amt_known;
  int rx_elapsed;
  logic [TMO_W-1:0] tmo_setting;
  logic [MTU_W-1:0] mtu_setting;

  reply_t fresh[$];
  reply_t pending[$];
  reply_t seen_reply;
  reply_t head_reply;
  bit in_fire_n;
  bit out_fire_n;
  bit calm;
  int errors;
  int cycles;
  int n_beats;
  int n_checked;
  int n_fin_acks;

  dir_row_t directed_rows [DIRECTED_ROWS];
  beat_t b;
  ending_t end_choice;
  int counted;
  int part;
  int i;
  logic [TMO_W-1:0] tmo_plan [3];
  logic [MTU_W-1:0] mtu_plan [3];

  segmented_transfer_receiver_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_ack_status    (in_ack_status),
    .in_name_matches  (in_name_matches),
    .in_seg_order     (in_seg_order),
    .in_seg_amount    (in_seg_amount),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_order        (out_order),
    .out_amount       (out_amount),
    .out_finish_status(out_finish_status),
    .out_error_code   (out_error_code),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    in_fire_n = (in_valid && !in_stall) === 1'b1;
    out_fire_n = (out_valid && !out_stall) === 1'b1;
    seen_reply = {out_kind, out_order, out_amount, out_finish_status, out_error_code,
                  out_last};
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Run stopped at cycle limit with %0d replies pending", pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 37);
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin
    if (out_fire_n) begin
      n_checked++;
      if (seen_reply.kind == KIND_FIN_ACK)
        n_fin_acks++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected reply kind %0d order %0d err %0d",
                                  seen_reply.kind, seen_reply.order, seen_reply.err));
      end else begin
        head_reply = pending.pop_front();
        if (seen_reply.kind !== head_reply.kind)
          report_mismatch($sformatf("kind %0d, want %0d", seen_reply.kind, head_reply.kind));
        if (seen_reply.order !== head_reply.order)
          report_mismatch($sformatf("order %0d, want %0d", seen_reply.order,
                                    head_reply.order));
        if (seen_reply.amount !== head_reply.amount)
          report_mismatch($sformatf("amount %0d, want %0d", seen_reply.amount,
                                    head_reply.amount));
        if (seen_reply.fin !== head_reply.fin)
          report_mismatch($sformatf("finish status %0d, want %0d", seen_reply.fin,
                                    head_reply.fin));
        if (seen_reply.err !== head_reply.err)
          report_mismatch($sformatf("error code %0d, want %0d", seen_reply.err,
                                    head_reply.err));
        if (seen_reply.last !== head_reply.last)
          report_mismatch($sformatf("last %0d, want %0d", seen_reply.last, head_reply.last));
      end
    end
  end

  function automatic reply_t make_reply(logic [KIND_W-1:0] kind, int order, int amount,
                                        logic fin, logic [ERR_W-1:0] err, logic last);
    reply_t r;
    r.kind = kind;
    r.order = SEG_W'(order);
    r.amount = SEG_W'(amount);
    r.fin = fin;
    r.err = err;
    r.last = last;
    return r;
  endfunction

  function automatic void fail_with(logic [ERR_W-1:0] code);
    rx_phase = PH_FAIL;
    fresh.push_back(make_reply(KIND_FAIL, 0, 0, 1'b0, code, 1'b1));
  endfunction

  function automatic void predict_replies(beat_t bt);
    int k;
    fresh.delete();
    if (rx_phase == PH_DONE || rx_phase == PH_FAIL)
      return;
    if (bt.action == ACT_EXIT) begin
      fail_with(ERR_EXIT);
      return;
    end
    if (bt.action == ACT_TICK) begin
      if (rx_elapsed < int'(ELAPSED_MAX))
        rx_elapsed++;
      if (rx_elapsed > int'(tmo_setting))
        fail_with(ERR_TIMEOUT);
      return;
    end
    if (rx_phase == PH_WAIT) begin
      if (bt.action != ACT_GET_ACK)
        return;
      if (bt.status == STATUS_NOT_FOUND)
        fail_with(ERR_NOT_FOUND);
      else if (mtu_setting <= MTU_OVERHEAD)
        fail_with(ERR_MTU_SMALL);
      else begin
        rx_phase = PH_RECV;
        rx_elapsed = 0;
      end
      return;
    end
    if (bt.action == ACT_SEGMENT) begin
      if (!bt.name_hit)
        return;
      if (!amt_known) begin
        if (bt.amount > AMOUNT_CAP) begin
          fail_with(ERR_CAPACITY);
          return;
        end
        amt_latched = int'(bt.amount);
        amt_known = 1'b1;
      end
      if (int'(bt.amount) != amt_latched)
        fail_with(ERR_AMOUNT);
      else if (bt.order >= bt.amount)
        fail_with(ERR_ORDER);
      else begin
        if (!seg_seen[bt.order]) begin
          seg_seen[bt.order] = 1'b1;
          seg_count++;
        end
        rx_elapsed = 0;
        fresh.push_back(make_reply(KIND_SEG_ACK, bt.order, bt.amount, 1'b0, '0, 1'b1));
      end
      return;
    end
    if (bt.action == ACT_FINISH) begin
      rx_elapsed = 0;
      if (amt_known && seg_count == amt_latched) begin
        rx_phase = PH_DONE;
        fresh.push_back(make_reply(KIND_FIN_ACK, 0, 0, 1'b0, '0, 1'b1));
        return;
      end
      fresh.push_back(make_reply(KIND_FIN_ACK, 0, 0, 1'b1, '0, 1'b0));
      if (amt_known)
        for (k = 0; k < amt_latched && k < MAX_SEGMENTS; k++)
          if (!seg_seen[k])
            fresh.push_back(make_reply(KIND_RETX, k, 0, 1'b0, '0, 1'b0));
      fresh[fresh.size()-1].last = 1'b1;
    end
  endfunction

  function automatic dir_row_t row(logic [ACTION_W-1:0] a, logic signed [STATUS_W-1:0] s,
                                   logic m, int o, int n, bit typed,
                                   logic [KIND_W-1:0] k, int ro, int rn, logic f);
    dir_row_t d;
    d.b = {a, s, m, SEG_W'(o), SEG_W'(n)};
    d.typed = typed;
    d.r = make_reply(k, ro, rn, f, '0, 1'b1);
    return d;
  endfunction

  // hold the beat until taken; valid stays high into the next beat
  task automatic offer(beat_t bt);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= bt.action;
    in_ack_status <= bt.status;
    in_name_matches <= bt.name_hit;
    in_seg_order <= bt.order;
    in_seg_amount <= bt.amount;
    do @(posedge clk); while (!in_fire_n);
    n_beats++;
  endtask

  task automatic issue(beat_t bt);
    offer(bt);
    predict_replies(bt);
    foreach (fresh[j])
      pending.push_back(fresh[j]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [TMO_W-1:0] tmo, logic [MTU_W-1:0] mtu);
    cfg_we <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(tmo);
    @(posedge clk);
    tmo_setting = tmo;
    cfg_index <= REG_MTU;
    cfg_wdata <= CFG_DATA_W'(mtu);
    @(posedge clk);
    mtu_setting = mtu;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic beat_t pick_beat(int progress);
    beat_t bt;
    int roll;
    int span;
    int k;
    bt.action = ACT_SEGMENT;
    bt.status = STATUS_W'($urandom);
    bt.name_hit = 1'b1;
    bt.order = SEG_W'($urandom);
    bt.amount = SEG_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 8)
      bt.name_hit = 1'b0;
    else if (roll < 16)
      bt.action = ACT_FINISH;
    else if (roll < 32 && rx_elapsed < int'(tmo_setting))
      bt.action = ACT_TICK;
    else if (roll >= 32 && roll < 37)
      bt.action = ACT_GET_ACK;
    else if (roll >= 37 && roll < 41)
      bt.action = ACTION_W'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
    if (bt.action == ACT_SEGMENT && bt.name_hit) begin
      span = 3 + (progress * 29) / RANDOM_ITEMS;
      if (span > MAX_SEGMENTS - 1)
        span = MAX_SEGMENTS - 1;
      bt.amount = SEG_W'(amt_latched);
      bt.order = SEG_W'($urandom_range(0, span));
      // keep the last missing index back so the transfer stays open
      if (!seg_seen[bt.order] && seg_count == amt_latched - 1)
        for (k = MAX_SEGMENTS - 1; k >= 0; k--)
          if (seg_seen[k])
            bt.order = SEG_W'(k);
    end
    return bt;
  endfunction

  initial begin
    rx_phase = PH_WAIT;
    seg_seen = '0;
    seg_count = 0;
    amt_latched = 0;
    amt_known = 1'b0;
    rx_elapsed = 0;
    tmo_setting = TIMEOUT_RESET;
    mtu_setting = MTU_RESET;
    calm = 1'b0;
    tmo_plan = '{8'd255, 8'd3, 8'd0};
    mtu_plan = '{10'd517, 10'd29, 10'd0};

    directed_rows = '{
      row(ACT_SEGMENT, 8'sd0, 1'b1, 0, 1, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_FINISH, 8'sd0, 1'b1, 0, 0, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_TICK, 8'sd0, 1'b0, 0, 0, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_SPARE_A, 8'sd127, 1'b1, 65535, 65535, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_SPARE_B, 8'sd0, 1'b0, 0, 0, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_SPARE_C, -8'sd128, 1'b1, 65535, 65535, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_GET_ACK, -8'sd128, 1'b0, 0, 0, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_GET_ACK, STATUS_NOT_FOUND, 1'b0, 0, 0, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_SEGMENT, 8'sd0, 1'b0, 65535, 65535, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_FINISH, 8'sd0, 1'b0, 0, 0, 1'b1, KIND_FIN_ACK, 0, 0, 1'b1),
      row(ACT_SEGMENT, 8'sd0, 1'b1, 31, 32, 1'b1, KIND_SEG_ACK, 31, 32, 1'b0),
      row(ACT_SEGMENT, 8'sd0, 1'b1, 0, 32, 1'b1, KIND_SEG_ACK, 0, 32, 1'b0),
      row(ACT_SEGMENT, 8'sd0, 1'b1, 0, 32, 1'b1, KIND_SEG_ACK, 0, 32, 1'b0),
      row(ACT_TICK, 8'sd0, 1'b0, 0, 0, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_FINISH, 8'sd0, 1'b0, 0, 0, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_SEGMENT, 8'sd0, 1'b1, 17, 32, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0),
      row(ACT_GET_ACK, 8'sd0, 1'b1, 0, 0, 1'b0, KIND_SEG_ACK, 0, 0, 1'b0)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apply_settings(8'd0, 10'd0);
    apply_settings(TIMEOUT_RESET, MTU_OVERHEAD);
    apply_settings(8'd255, 10'd517);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      offer(directed_rows[i].b);
      predict_replies(directed_rows[i].b);
      if (directed_rows[i].typed)
        pending.push_back(directed_rows[i].r);
      else
        foreach (fresh[j])
          pending.push_back(fresh[j]);
    end

    counted = 0;
    for (part = 0; part < 3; part++) begin
      settle();
      apply_settings(tmo_plan[part], mtu_plan[part]);
      while (counted < (part + 1) * RANDOM_ITEMS / 3) begin
        calm = counted >= 200 && counted < 280;
        b = pick_beat(counted);
        issue(b);
        counted++;
      end
    end
    calm = 1'b0;

    settle();
    end_choice = ending_t'($urandom_range(0, 4));
    apply_settings(TMO_W'($urandom_range(0, 4)), 10'd517);
    b = {ACT_SEGMENT, 8'sd0, 1'b1, 16'd0, SEG_W'(amt_latched)};
    case (end_choice)
      END_COMPLETE: begin
        for (i = 0; i < amt_latched; i++)
          if (!seg_seen[i]) begin
            b.order = SEG_W'(i);
            issue(b);
          end
        b.action = ACT_FINISH;
        issue(b);
      end
      END_EXIT: begin
        b.action = ACT_EXIT;
        issue(b);
      end
      END_TIMEOUT: begin
        b.action = ACT_TICK;
        while (rx_phase != PH_FAIL)
          issue(b);
      end
      END_AMOUNT: begin
        b.amount = SEG_W'($urandom);
        if (b.amount == SEG_W'(amt_latched))
          b.amount = ~b.amount;
        issue(b);
      end
      default: begin
        b.order = SEG_W'($urandom_range(amt_latched, 65535));
        issue(b);
      end
    endcase

    // drop everything after the transfer has closed
    for (i = 0; i < 10; i++)
      issue(pick_beat(RANDOM_ITEMS));
    b.action = ACT_EXIT;
    issue(b);

    settle();
    if (pending.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", pending.size()));

    $display("Run covered %0d beats, %0d replies checked, %0d finish acks, end by %s",
             n_beats, n_checked, n_fin_acks, end_choice.name());
    $display("Segments held %0d of %0d; timeouts 255, 3 and 0 seen while receiving",
             seg_count, amt_latched);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
